/* sv/spsb_pkg.sv */
package spsb_pkg;

    localparam int SCREEN_COLUMNS_DEF = 128;
    localparam int SCREEN_PAGES_DEF   = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_X_POS        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_POS        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_WIDTH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_PAGES = 2'd3;

    localparam logic [8:0] X_POS_RESET        = 9'd0;
    localparam logic [5:0] Y_POS_RESET        = 6'd0;
    localparam logic [7:0] SPRITE_WIDTH_RESET = 8'd8;
    localparam logic [3:0] SPRITE_PAGES_RESET = 4'd1;

    localparam logic [3:0] MAX_SPRITE_PAGES = 4'd8;

    typedef struct packed {
        logic [7:0] bitmap_byte;
        logic       sprite_start;
    } in_item_t;

    typedef struct packed {
        logic [2:0] disp_page;
        logic [6:0] disp_column;
        logic [7:0] pixel_byte;
        logic       row_last;
        logic       sprite_last;
    } out_item_t;

endpackage

/* sv/spsb_line_store.sv */
module spsb_line_store #(
    parameter int DEPTH  = spsb_pkg::SCREEN_COLUMNS_DEF,
    parameter int ADDR_W = $clog2(spsb_pkg::SCREEN_COLUMNS_DEF)
) (
    input  logic              clk,
    input  logic              en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // read-first: the read returns the entry as it was before this write
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/sprite_page_shift_blitter_core.sv */
// Sprite blitter for a page-organized display: takes one sprite byte per item in row-major
// order and emits display bytes placed at an exact pixel row, one item per clock unless
// stalled. A visible item goes through s1_reg and out_item_reg; off-screen items and
// items past the end of the sprite are consumed without a result. The previous page row
// lives in a single-port, read-first line store of SCREEN_COLUMNS bytes, read and written
// once per visible item at its display column, which is what sets the one-item-per-cycle
// rate. The store needs no clearing pass after reset; every row after the first reads only
// entries written by the row above it. Write configuration only while the block is idle.
module sprite_page_shift_blitter_core #(
    parameter int SCREEN_COLUMNS = spsb_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_PAGES   = spsb_pkg::SCREEN_PAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [spsb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [spsb_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  spsb_pkg::in_item_t                  in_item,

    output logic                                out_valid,
    input  logic                                out_stall,
    output spsb_pkg::out_item_t                 out_item
);

    localparam int IDX_W = $clog2(SCREEN_COLUMNS);
    localparam logic [8:0]       COL_LIMIT  = 9'(SCREEN_COLUMNS);
    localparam logic [IDX_W-1:0] COL_LAST   = IDX_W'(SCREEN_COLUMNS - 1);
    localparam logic [4:0]       PAGE_LIMIT = 5'(SCREEN_PAGES);
    localparam logic [4:0]       PAGE_LAST  = 5'(SCREEN_PAGES - 1);

    typedef struct packed {
        logic [2:0] disp_page;
        logic [6:0] disp_column;
        logic [7:0] bitmap_byte;
        logic [2:0] shift;
        logic       use_prev;
        logic       use_cur;
        logic       row_last;
        logic       sprite_last;
    } s1_t;

    // configuration
    logic [8:0] x_pos_reg;
    logic [5:0] y_pos_reg;
    logic [7:0] sprite_width_reg;
    logic [3:0] sprite_pages_reg;

    // position counters
    logic [3:0] row_count_reg, row_count_next;
    logic [7:0] col_count_reg, col_count_next;

    // pipeline
    logic       s1_valid_reg, s1_valid_next;
    s1_t        s1_reg, s1_next;
    logic       out_valid_reg, out_valid_next;
    spsb_pkg::out_item_t out_item_reg, out_item_next;

    logic       accept;
    logic       s1_adv;

    logic [3:0]       rp;
    logic [7:0]       c;
    logic [2:0]       shift;
    logic [3:0]       pages;
    logic [3:0]       total;
    logic             done;
    logic [4:0]       dp;
    logic [9:0]       col;
    logic             vis;
    logic [IDX_W-1:0] idx;
    logic [7:0]       width_m1;
    logic [7:0]       nxt;
    logic             rlast;
    logic             slast;

    logic [7:0]       prev_byte;
    logic [7:0]       prev_part;
    logic [7:0]       cur_part;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pos_reg        <= spsb_pkg::X_POS_RESET;
            y_pos_reg        <= spsb_pkg::Y_POS_RESET;
            sprite_width_reg <= spsb_pkg::SPRITE_WIDTH_RESET;
            sprite_pages_reg <= spsb_pkg::SPRITE_PAGES_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                spsb_pkg::REG_X_POS:        x_pos_reg        <= cfg_data[8:0];
                spsb_pkg::REG_Y_POS:        y_pos_reg        <= cfg_data[5:0];
                spsb_pkg::REG_SPRITE_WIDTH: sprite_width_reg <= cfg_data[7:0];
                spsb_pkg::REG_SPRITE_PAGES: sprite_pages_reg <= cfg_data[3:0];
                default:                    x_pos_reg        <= x_pos_reg;
            endcase
        end
    end

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    // position of the incoming item
    always_comb
    begin
        rp       = in_item.sprite_start ? 4'd0 : row_count_reg;
        c        = in_item.sprite_start ? 8'd0 : col_count_reg;
        shift    = y_pos_reg[2:0];
        pages    = (sprite_pages_reg > spsb_pkg::MAX_SPRITE_PAGES) ?
                   spsb_pkg::MAX_SPRITE_PAGES : sprite_pages_reg;
        total    = pages + {3'd0, shift != 3'd0};
        done     = rp >= total;
        dp       = {2'd0, y_pos_reg[5:3]} + {1'b0, rp};
        col      = {x_pos_reg[8], x_pos_reg} + {2'd0, c};
        vis      = !done && (dp < PAGE_LIMIT) && !col[9] && (col[8:0] < COL_LIMIT);
        idx      = col[IDX_W-1:0];
        width_m1 = sprite_width_reg - 8'd1;
        nxt      = c + 8'd1;
        rlast    = (c == width_m1) || (idx == COL_LAST);
        slast    = rlast && ((rp + 4'd1 == total) || (dp == PAGE_LAST));

        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (accept)
        begin
            // a finished sprite holds its counters until the next start
            if (done)
            begin
                row_count_next = rp;
                col_count_next = c;
            end
            else if (nxt == sprite_width_reg)
            begin
                row_count_next = rp + 4'd1;
                col_count_next = 8'd0;
            end
            else
            begin
                row_count_next = rp;
                col_count_next = nxt;
            end
        end

        s1_next.disp_page   = dp[2:0];
        s1_next.disp_column = col[6:0];
        s1_next.bitmap_byte = in_item.bitmap_byte;
        s1_next.shift       = shift;
        s1_next.use_prev    = (shift != 3'd0) && (rp != 4'd0);
        s1_next.use_cur     = (shift == 3'd0) || (rp < pages);
        s1_next.row_last    = rlast;
        s1_next.sprite_last = slast;
    end

    spsb_line_store #(
        .DEPTH  (SCREEN_COLUMNS),
        .ADDR_W (IDX_W)
    ) u_line_store (
        .clk   (clk),
        .en    (accept && vis),
        .addr  (idx),
        .wdata (in_item.bitmap_byte),
        .rdata (prev_byte)
    );

    // compose upper page tail with current page head
    always_comb
    begin
        prev_part = s1_reg.use_prev ? (prev_byte >> (4'd8 - {1'b0, s1_reg.shift})) : 8'd0;
        cur_part  = s1_reg.use_cur ? (s1_reg.bitmap_byte << s1_reg.shift) : 8'd0;

        out_item_next.disp_page   = s1_reg.disp_page;
        out_item_next.disp_column = s1_reg.disp_column;
        out_item_next.pixel_byte  = prev_part | cur_part;
        out_item_next.row_last    = s1_reg.row_last;
        out_item_next.sprite_last = s1_reg.sprite_last;

        if (accept)
            s1_valid_next = vis;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= 4'd0;
            col_count_reg <= 8'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
        if (s1_adv && s1_valid_reg)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_last_nesting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_item_reg.sprite_last || out_item_reg.row_last))
        else $error("sprite_last without row_last");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with pipeline not full");

    a_visible_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && vis) |=> s1_valid_reg)
        else $error("visible item lost at stage one");

    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(row_count_reg) && $stable(col_count_reg)))
        else $error("counters moved without an accepted item");
`endif

endmodule
